### sv/mfsp_pkg.sv
// shared types, constants and helpers for the midi file stream parser
// no dependencies
`default_nettype none

package mfsp_pkg;

  localparam int unsigned DataW   = 8;
  localparam int unsigned OutW    = 120;
  localparam int unsigned KindW   = 3;
  localparam logic [7:0]  LimitRst = 8'd254;
  localparam logic [31:0] VlqMax  = 32'h0fff_ffff;

  typedef enum logic [3:0] {
    PH_HEADER = 4'd0,
    PH_TRACK  = 4'd1,
    PH_VTIME  = 4'd2,
    PH_EVENT  = 4'd3,
    PH_DATA1  = 4'd4,
    PH_DATA2  = 4'd5,
    PH_MTYPE  = 4'd6,
    PH_MLEN   = 4'd7,
    PH_MPAY   = 4'd8
  } phase_t;

  typedef enum logic [KindW-1:0] {
    KIND_HEADER   = 3'd0,
    KIND_TRACK    = 3'd1,
    KIND_DELTA    = 3'd2,
    KIND_CHANNEL  = 3'd3,
    KIND_META_HDR = 3'd4,
    KIND_META_PAY = 3'd5,
    KIND_ERROR    = 3'd6
  } kind_t;

  localparam logic [7:0] StatusMeta = 8'hff;
  localparam logic [7:0] StatusSys  = 8'hf0;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = 8'h4d;
      2'd1:    m = 8'h54;
      2'd2:    m = 8'h68;
      default: m = 8'h64;
    endcase
    return m;
  endfunction

  function automatic logic [1:0] status_size(input logic [7:0] s);
    return (s[7:4] == 4'hc || s[7:4] == 4'hd) ? 2'd2 : 2'd3;
  endfunction

endpackage

`default_nettype wire

### sv/midi_file_stream_parser_unit.sv
// midi file stream parser: header, track chunk, delta times, channel and meta events
// depends on mfsp_pkg
`default_nettype none

// channel  | dir | handshake            | payload
// in       | in  | in_tvalid/in_tready  | in_tdata: data_byte
// out      | out | out_tvalid/out_tready| out_tdata, out_tuser: result_kind, out_tlast
// cfg      | in  | cfg_valid/cfg_ready  | cfg_data: meta_byte_limit
//
// one byte accepted per cycle unless the output stalls; the result is registered
// the rate is set by the single state update between the input and result registers
// synchronous active-low reset clears all parse state, limit resets to 254
// a stalled result holds the result register; the input register still takes one byte
module midi_file_stream_parser_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [mfsp_pkg::DataW-1:0]   in_tdata,   // [7:0] data_byte
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // [31:0] value, [47:32] file_format, [63:48] track_total, [79:64] division_word,
  // [87:80] status_byte, [94:88] data_first, [101:95] data_second,
  // [103:102] event_bytes, [111:104] meta_type, [119:112] payload_byte
  output logic [mfsp_pkg::OutW-1:0]         out_tdata,
  output logic [mfsp_pkg::KindW-1:0]        out_tuser,  // [2:0] result_kind
  output logic                              out_tlast,  // payload_last
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [7:0]                   cfg_data    // [7:0] meta_byte_limit
);

  logic                  in_v_r;
  logic [7:0]            in_byte_r;
  logic                  advance;

  mfsp_pkg::phase_t      phase_r, phase_nxt;
  logic [3:0]            idx_r, idx_nxt;
  logic [31:0]           acc_r, acc_nxt;
  logic [15:0]           fmt_r, fmt_nxt;
  logic [15:0]           trk_r, trk_nxt;
  logic [7:0]            rs_r, rs_nxt;
  logic [1:0]            psize_r, psize_nxt;
  logic [7:0]            held_r, held_nxt;
  logic [7:0]            mtype_r, mtype_nxt;
  logic [27:0]           mrem_r, mrem_nxt;
  logic [7:0]            mfwd_r, mfwd_nxt;
  logic                  err_r, err_nxt;
  logic [7:0]            limit_r;

  logic                  out_v_r;
  logic [mfsp_pkg::OutW-1:0]  out_data_r;
  mfsp_pkg::kind_t       out_kind_r;
  logic                  out_last_r;

  logic                  res_v;
  mfsp_pkg::kind_t       res_kind;
  logic                  res_last;
  logic [31:0]           r_value;
  logic [15:0]           r_fmt, r_trk, r_div;
  logic [7:0]            r_status, r_mtype, r_pay;
  logic [6:0]            r_d1, r_d2;
  logic [1:0]            r_evb;

  logic [7:0]            b;
  logic [31:0]           q_acc;
  logic [3:0]            q_idx;
  logic                  q_err;
  logic [31:0]           shift_acc;

  assign b         = in_byte_r;
  assign q_acc     = {acc_r[24:0], b[6:0]};
  assign q_idx     = idx_r + 4'd1;
  assign q_err     = (|acc_r[31:21]) || (q_idx > 4'd5);
  assign shift_acc = {acc_r[23:0], b};

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;
  assign cfg_ready = 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    acc_nxt   = acc_r;
    fmt_nxt   = fmt_r;
    trk_nxt   = trk_r;
    rs_nxt    = rs_r;
    psize_nxt = psize_r;
    held_nxt  = held_r;
    mtype_nxt = mtype_r;
    mrem_nxt  = mrem_r;
    mfwd_nxt  = mfwd_r;
    err_nxt   = err_r;
    res_v     = 1'b0;
    res_kind  = mfsp_pkg::KIND_HEADER;
    res_last  = 1'b0;
    r_value   = '0;
    r_fmt     = '0;
    r_trk     = '0;
    r_div     = '0;
    r_status  = '0;
    r_d1      = '0;
    r_d2      = '0;
    r_evb     = '0;
    r_mtype   = '0;
    r_pay     = '0;
    if (err_r) begin
      res_v    = 1'b1;
      res_kind = mfsp_pkg::KIND_ERROR;
    end else begin
      case (phase_r)
        mfsp_pkg::PH_HEADER: begin
          idx_nxt = idx_r + 4'd1;
          if (idx_r < 4'd4) begin
            if (b != mfsp_pkg::magic_byte(idx_r[1:0])) begin
              err_nxt  = 1'b1;
              res_v    = 1'b1;
              res_kind = mfsp_pkg::KIND_ERROR;
            end
          end else if (idx_r < 4'd8) begin
            acc_nxt = shift_acc;
          end else if (idx_r < 4'd10) begin
            fmt_nxt = {fmt_r[7:0], b};
          end else if (idx_r < 4'd12) begin
            trk_nxt = {trk_r[7:0], b};
          end else if (idx_r == 4'd12) begin
            held_nxt = b;
          end else begin
            res_v     = 1'b1;
            res_kind  = mfsp_pkg::KIND_HEADER;
            r_value   = acc_r;
            r_fmt     = fmt_r;
            r_trk     = trk_r;
            r_div     = {held_r, b};
            phase_nxt = mfsp_pkg::PH_TRACK;
            idx_nxt   = '0;
            acc_nxt   = '0;
          end
        end
        mfsp_pkg::PH_TRACK: begin
          if (idx_r >= 4'd4) acc_nxt = shift_acc;
          if (idx_r == 4'd7) begin
            res_v     = 1'b1;
            res_kind  = mfsp_pkg::KIND_TRACK;
            r_value   = shift_acc;
            phase_nxt = mfsp_pkg::PH_VTIME;
            idx_nxt   = '0;
            acc_nxt   = '0;
          end else begin
            idx_nxt = idx_r + 4'd1;
          end
        end
        mfsp_pkg::PH_VTIME: begin
          idx_nxt = q_idx;
          if (q_err) begin
            err_nxt  = 1'b1;
            res_v    = 1'b1;
            res_kind = mfsp_pkg::KIND_ERROR;
          end else begin
            acc_nxt = q_acc;
            if (!b[7]) begin
              res_v     = 1'b1;
              res_kind  = mfsp_pkg::KIND_DELTA;
              r_value   = q_acc;
              phase_nxt = mfsp_pkg::PH_EVENT;
            end
          end
        end
        mfsp_pkg::PH_EVENT, mfsp_pkg::PH_DATA1: begin
          if (phase_r == mfsp_pkg::PH_EVENT && b == mfsp_pkg::StatusMeta) begin
            phase_nxt = mfsp_pkg::PH_MTYPE;
          end else if (phase_r == mfsp_pkg::PH_EVENT && b >= mfsp_pkg::StatusSys) begin
            err_nxt  = 1'b1;
            res_v    = 1'b1;
            res_kind = mfsp_pkg::KIND_ERROR;
          end else if (phase_r == mfsp_pkg::PH_EVENT && b[7]) begin
            rs_nxt    = b;
            psize_nxt = mfsp_pkg::status_size(b);
            phase_nxt = mfsp_pkg::PH_DATA1;
          end else if (phase_r == mfsp_pkg::PH_EVENT && rs_r == 8'd0) begin
            err_nxt  = 1'b1;
            res_v    = 1'b1;
            res_kind = mfsp_pkg::KIND_ERROR;
          end else if (psize_r == 2'd3) begin
            held_nxt  = {1'b0, b[6:0]};
            phase_nxt = mfsp_pkg::PH_DATA2;
          end else begin
            res_v     = 1'b1;
            res_kind  = mfsp_pkg::KIND_CHANNEL;
            r_status  = rs_r;
            r_d1      = b[6:0];
            r_evb     = 2'd2;
            phase_nxt = mfsp_pkg::PH_VTIME;
            idx_nxt   = '0;
            acc_nxt   = '0;
          end
        end
        mfsp_pkg::PH_DATA2: begin
          res_v     = 1'b1;
          res_kind  = mfsp_pkg::KIND_CHANNEL;
          r_status  = rs_r;
          r_d1      = held_r[6:0];
          r_d2      = b[6:0];
          r_evb     = 2'd3;
          phase_nxt = mfsp_pkg::PH_VTIME;
          idx_nxt   = '0;
          acc_nxt   = '0;
        end
        mfsp_pkg::PH_MTYPE: begin
          mtype_nxt = b;
          phase_nxt = mfsp_pkg::PH_MLEN;
          idx_nxt   = '0;
          acc_nxt   = '0;
        end
        mfsp_pkg::PH_MLEN: begin
          idx_nxt = q_idx;
          if (q_err) begin
            err_nxt  = 1'b1;
            res_v    = 1'b1;
            res_kind = mfsp_pkg::KIND_ERROR;
          end else begin
            acc_nxt = q_acc;
            if (!b[7]) begin
              res_v    = 1'b1;
              res_kind = mfsp_pkg::KIND_META_HDR;
              r_value  = q_acc;
              r_mtype  = mtype_r;
              res_last = (q_acc == 32'd0) || (limit_r == 8'd0);
              mrem_nxt = q_acc[27:0];
              mfwd_nxt = '0;
              if (q_acc == 32'd0) begin
                phase_nxt = mfsp_pkg::PH_VTIME;
                idx_nxt   = '0;
                acc_nxt   = '0;
              end else begin
                phase_nxt = mfsp_pkg::PH_MPAY;
              end
            end
          end
        end
        mfsp_pkg::PH_MPAY: begin
          if (mfwd_r < limit_r) begin
            res_v    = 1'b1;
            res_kind = mfsp_pkg::KIND_META_PAY;
            r_mtype  = mtype_r;
            r_pay    = b;
            res_last = (mrem_r == 28'd1) || (mfwd_r + 8'd1 == limit_r);
            mfwd_nxt = mfwd_r + 8'd1;
          end
          mrem_nxt = mrem_r - 28'd1;
          if (mrem_r - 28'd1 == 28'd0) begin
            phase_nxt = mfsp_pkg::PH_VTIME;
            idx_nxt   = '0;
            acc_nxt   = '0;
          end
        end
        default: begin
          err_nxt  = 1'b1;
          res_v    = 1'b1;
          res_kind = mfsp_pkg::KIND_ERROR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= mfsp_pkg::LimitRst;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= mfsp_pkg::PH_HEADER;
      idx_r   <= '0;
      acc_r   <= '0;
      fmt_r   <= '0;
      trk_r   <= '0;
      rs_r    <= '0;
      psize_r <= '0;
      held_r  <= '0;
      mtype_r <= '0;
      mrem_r  <= '0;
      mfwd_r  <= '0;
      err_r   <= 1'b0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      acc_r   <= acc_nxt;
      fmt_r   <= fmt_nxt;
      trk_r   <= trk_nxt;
      rs_r    <= rs_nxt;
      psize_r <= psize_nxt;
      held_r  <= held_nxt;
      mtype_r <= mtype_nxt;
      mrem_r  <= mrem_nxt;
      mfwd_r  <= mfwd_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= res_v;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_v) begin
      out_kind_r <= res_kind;
      out_last_r <= res_last;
      out_data_r <= {r_pay, r_mtype, r_evb, r_d2, r_d1, r_status,
                     r_div, r_trk, r_fmt, r_value};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

### sv/mfsp_checker.sv
// port-level checks for the midi file stream parser, bound to the top level
// depends on mfsp_pkg and midi_file_stream_parser_unit
`default_nettype none

module mfsp_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [mfsp_pkg::OutW-1:0]   out_tdata,
  input wire logic [mfsp_pkg::KindW-1:0]  out_tuser,
  input wire logic                        out_tlast
);

  logic err_seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_seen_r <= 1'b0;
    end else if (out_tvalid && out_tready && out_tuser == mfsp_pkg::KIND_ERROR) begin
      err_seen_r <= 1'b1;
    end
  end

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // once an error item is delivered, every later item is an error
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && err_seen_r |-> out_tuser == mfsp_pkg::KIND_ERROR)
    else $error("non-error item after error");

  // last flag only on meta items
  a_last_meta: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |->
      out_tuser == mfsp_pkg::KIND_META_HDR || out_tuser == mfsp_pkg::KIND_META_PAY)
    else $error("tlast on non-meta item");

  // channel items carry a status byte and a 2 or 3 byte length
  a_chan_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == mfsp_pkg::KIND_CHANNEL |->
      out_tdata[87] && (out_tdata[103:102] == 2'd2 || out_tdata[103:102] == 2'd3))
    else $error("bad channel item fields");

  // stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled item changed");

endmodule

bind midi_file_stream_parser_unit mfsp_checker u_mfsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

### sim/tb_midi_file_stream_parser_unit.sv
// testbench for midi_file_stream_parser_unit: byte streams of midi files in, parse items out
// a built-in parser model predicts every item; depends on mfsp_pkg and the unit
`timescale 1ns / 1ps

module tb_midi_file_stream_parser_unit;

  localparam int StallLimit = 2000;
  localparam logic [31:0] HdrTag = "MThd";

  typedef struct packed {
    mfsp_pkg::kind_t kind;
    logic [31:0] value;
    logic [15:0] fmt;
    logic [15:0] tracks;
    logic [15:0] division;
    logic [7:0]  status;
    logic [6:0]  first;
    logic [6:0]  second;
    logic [1:0]  nbytes;
    logic [7:0]  mtype;
    logic [7:0]  pbyte;
    logic        plast;
  } parse_rec_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [mfsp_pkg::DataW-1:0]     in_tdata = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [mfsp_pkg::OutW-1:0]      out_tdata;
  logic [mfsp_pkg::KindW-1:0]     out_tuser;
  logic                           out_tlast;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [7:0]                     cfg_data = '0;

  // parser model state
  mfsp_pkg::phase_t p_phase;
  logic [3:0]  p_index;
  logic [31:0] p_acc;
  logic [15:0] p_fmt;
  logic [15:0] p_tracks;
  logic [7:0]  p_running;
  logic [1:0]  p_size;
  logic [7:0]  p_held;
  logic [7:0]  p_mtype;
  logic [27:0] p_remain;
  logic [7:0]  p_fwd;
  logic        p_fault;
  logic [7:0]  meta_limit;

  parse_rec_t parsed_q[$];
  int         fail_count = 0;
  int         quiet_cycles = 0;
  int         send_idle = 0;
  int         recv_idle = 0;
  int         bytes_sent = 0;
  int         early_fault;
  logic [7:0] stim_status = 8'h00;

  midi_file_stream_parser_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic void reset_model();
    meta_limit = mfsp_pkg::LimitRst;
    p_phase = mfsp_pkg::PH_HEADER;
    p_index = '0;
    p_acc = '0;
    p_fmt = '0;
    p_tracks = '0;
    p_running = '0;
    p_size = '0;
    p_held = '0;
    p_mtype = '0;
    p_remain = '0;
    p_fwd = '0;
    p_fault = 1'b0;
  endfunction

  function automatic void restart_count(input mfsp_pkg::phase_t ph);
    p_phase = ph;
    p_index = '0;
    p_acc = '0;
  endfunction

  // -1 bad quantity, 0 more bytes, 1 quantity complete
  function automatic int take_vlq(input logic [7:0] b);
    logic [38:0] v;
    v = {p_acc, b[6:0]};
    p_index = p_index + 4'd1;
    if (v > mfsp_pkg::VlqMax || p_index > 4'd5) return -1;
    p_acc = v[31:0];
    return b[7] ? 0 : 1;
  endfunction

  function automatic logic take_first_data(input logic [7:0] b, inout parse_rec_t r);
    if (p_size == 2'd3) begin
      p_held = {1'b0, b[6:0]};
      p_phase = mfsp_pkg::PH_DATA2;
      return 1'b0;
    end
    r.kind = mfsp_pkg::KIND_CHANNEL;
    r.status = p_running;
    r.first = b[6:0];
    r.nbytes = 2'd2;
    restart_count(mfsp_pkg::PH_VTIME);
    return 1'b1;
  endfunction

  function automatic void parse_midi_byte(input logic [7:0] b);
    parse_rec_t r;
    logic       emit;
    logic       bad;
    int         q;
    r = '0;
    emit = 1'b0;
    bad = p_fault;
    if (!bad) begin
      case (p_phase)
        mfsp_pkg::PH_HEADER: begin
          if (p_index < 4'd4) begin
            if (b != HdrTag[8*(3 - p_index[1:0]) +: 8]) bad = 1'b1;
          end else if (p_index < 4'd8) begin
            p_acc = {p_acc[23:0], b};
          end else if (p_index < 4'd10) begin
            p_fmt = {p_fmt[7:0], b};
          end else if (p_index < 4'd12) begin
            p_tracks = {p_tracks[7:0], b};
          end else if (p_index == 4'd12) begin
            p_held = b;
          end else begin
            r.kind = mfsp_pkg::KIND_HEADER;
            r.value = p_acc;
            r.fmt = p_fmt;
            r.tracks = p_tracks;
            r.division = {p_held, b};
            emit = 1'b1;
            restart_count(mfsp_pkg::PH_TRACK);
          end
          if (!emit && !bad) p_index = p_index + 4'd1;
        end
        mfsp_pkg::PH_TRACK: begin
          if (p_index >= 4'd4) p_acc = {p_acc[23:0], b};
          if (p_index == 4'd7) begin
            r.kind = mfsp_pkg::KIND_TRACK;
            r.value = p_acc;
            emit = 1'b1;
            restart_count(mfsp_pkg::PH_VTIME);
          end else begin
            p_index = p_index + 4'd1;
          end
        end
        mfsp_pkg::PH_VTIME: begin
          q = take_vlq(b);
          if (q < 0) begin
            bad = 1'b1;
          end else if (q > 0) begin
            r.kind = mfsp_pkg::KIND_DELTA;
            r.value = p_acc;
            emit = 1'b1;
            p_phase = mfsp_pkg::PH_EVENT;
          end
        end
        mfsp_pkg::PH_EVENT: begin
          if (b == mfsp_pkg::StatusMeta) begin
            p_phase = mfsp_pkg::PH_MTYPE;
          end else if (b >= mfsp_pkg::StatusSys) begin
            bad = 1'b1;
          end else if (b[7]) begin
            p_running = b;
            p_size = (b[7:5] == 3'b110) ? 2'd2 : 2'd3;
            p_phase = mfsp_pkg::PH_DATA1;
          end else if (p_running == 8'h00) begin
            bad = 1'b1;
          end else begin
            emit = take_first_data(b, r);
          end
        end
        mfsp_pkg::PH_DATA1: emit = take_first_data(b, r);
        mfsp_pkg::PH_DATA2: begin
          r.kind = mfsp_pkg::KIND_CHANNEL;
          r.status = p_running;
          r.first = p_held[6:0];
          r.second = b[6:0];
          r.nbytes = 2'd3;
          emit = 1'b1;
          restart_count(mfsp_pkg::PH_VTIME);
        end
        mfsp_pkg::PH_MTYPE: begin
          p_mtype = b;
          restart_count(mfsp_pkg::PH_MLEN);
        end
        mfsp_pkg::PH_MLEN: begin
          q = take_vlq(b);
          if (q < 0) begin
            bad = 1'b1;
          end else if (q > 0) begin
            r.kind = mfsp_pkg::KIND_META_HDR;
            r.value = p_acc;
            r.mtype = p_mtype;
            r.plast = (p_acc == 0 || meta_limit == 8'd0);
            emit = 1'b1;
            p_remain = p_acc[27:0];
            p_fwd = '0;
            if (p_acc == 0) restart_count(mfsp_pkg::PH_VTIME);
            else p_phase = mfsp_pkg::PH_MPAY;
          end
        end
        mfsp_pkg::PH_MPAY: begin
          if (p_fwd < meta_limit) begin
            r.kind = mfsp_pkg::KIND_META_PAY;
            r.mtype = p_mtype;
            r.pbyte = b;
            r.plast = (p_remain == 28'd1) || ({1'b0, p_fwd} + 9'd1 == {1'b0, meta_limit});
            emit = 1'b1;
            p_fwd = p_fwd + 8'd1;
          end
          p_remain = p_remain - 28'd1;
          if (p_remain == 0) restart_count(mfsp_pkg::PH_VTIME);
        end
        default: bad = 1'b1;
      endcase
    end
    if (bad) begin
      p_fault = 1'b1;
      r = '0;
      r.kind = mfsp_pkg::KIND_ERROR;
      emit = 1'b1;
    end
    if (emit) parsed_q.push_back(r);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    parse_rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (parsed_q.size() == 0) begin
        $error("result_kind: expected none, got %0d", out_tuser);
        fail_count++;
      end else begin
        want = parsed_q.pop_front();
        check_field("result_kind", want.kind, out_tuser);
        check_field("value", want.value, out_tdata[31:0]);
        check_field("file_format", want.fmt, out_tdata[47:32]);
        check_field("track_total", want.tracks, out_tdata[63:48]);
        check_field("division_word", want.division, out_tdata[79:64]);
        check_field("status_byte", want.status, out_tdata[87:80]);
        check_field("data_first", want.first, out_tdata[94:88]);
        check_field("data_second", want.second, out_tdata[101:95]);
        check_field("event_bytes", want.nbytes, out_tdata[103:102]);
        check_field("meta_type", want.mtype, out_tdata[111:104]);
        check_field("payload_byte", want.pbyte, out_tdata[119:112]);
        check_field("payload_last", want.plast, out_tlast);
      end
    end
  end

  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("tb_midi_file_stream_parser_unit: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = b;
    do @(posedge clk); while (!in_tready);
    parse_midi_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid = 1'b0;
    while (parsed_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_meta_limit(input logic [7:0] v);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    meta_limit = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_word(input logic [31:0] w, input int n);
    for (int i = n - 1; i >= 0; i--) send_byte(w[8*i +: 8]);
  endtask

  // extra leading 0x80 bytes keep the value but lengthen the quantity
  task automatic send_quantity(input logic [31:0] v, input int pad);
    int groups;
    groups = 1;
    while (groups < 5 && (v >> (7 * groups)) != 0) groups++;
    if (pad > 5 - groups) pad = 5 - groups;
    repeat (pad) send_byte(8'h80);
    for (int g = groups - 1; g >= 0; g--) send_byte({g != 0, v[7*g +: 7]});
  endtask

  function automatic logic [31:0] random_delta();
    case ($urandom_range(19))
      0:             return $urandom_range(32'h0fff_ffff);
      1, 2:          return $urandom_range(32'h001f_ffff);
      3, 4, 5, 6, 7: return $urandom_range(16383);
      default:       return $urandom_range(127);
    endcase
  endfunction

  function automatic logic [7:0] random_data();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'h7f;
      2:       return 8'h80 | 8'($urandom_range(127));
      default: return 8'($urandom_range(127));
    endcase
  endfunction

  task automatic send_delta();
    send_quantity(random_delta(), ($urandom_range(9) == 0) ? $urandom_range(4) : 0);
  endtask

  task automatic send_channel(input logic [7:0] status, input bit running);
    logic [7:0] first;
    logic [7:0] second;
    first = random_data();
    second = random_data();
    if (running) begin
      first[7] = 1'b0;
    end else begin
      stim_status = status;
      send_byte(status);
    end
    send_byte(first);
    if (status[7:5] != 3'b110) send_byte(second);
  endtask

  task automatic send_meta(input logic [7:0] mtype, input logic [27:0] len);
    send_byte(mfsp_pkg::StatusMeta);
    send_byte(mtype);
    send_quantity({4'd0, len}, ($urandom_range(7) == 0) ? $urandom_range(4) : 0);
    repeat (len) send_byte(8'($urandom_range(255)));
  endtask

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(2))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_file_header();
    logic [31:0] tag;
    tag = HdrTag;
    if (early_fault == 1) tag = tag ^ (32'h1 << $urandom_range(31));
    send_word(tag, 4);
    send_word(pick_extreme(), 4);
    send_word(pick_extreme(), 2);
    send_word(pick_extreme(), 2);
    send_word(pick_extreme(), 2);
    send_word($urandom, 4);
    send_word(pick_extreme(), 4);
  endtask

  task automatic test_channel_events();
    send_quantity(32'd0, 0);
    // data byte with no status seen yet
    if (early_fault == 2) begin
      send_byte(8'($urandom_range(127)));
      send_quantity(32'd0, 0);
    end
    for (int n = 8; n <= 14; n++) begin
      send_channel({n[3:0], 4'($urandom_range(15))}, 1'b0);
      case (n)
        8:       send_quantity(mfsp_pkg::VlqMax, 0);
        9:       send_quantity(32'h7f, 4);
        default: send_delta();
      endcase
    end
    repeat (3) begin
      send_channel(stim_status, 1'b1);
      send_delta();
    end
  endtask

  task automatic test_meta_limits();
    send_meta(8'($urandom_range(255)), 28'd0);
    send_quantity(32'd1, 0);
    send_meta(8'($urandom_range(255)), 28'd3);
    drain_results();
    write_meta_limit(8'd0);
    send_quantity(32'd0, 0);
    send_meta(8'($urandom_range(255)), 28'd2);
    drain_results();
    write_meta_limit(8'd2);
    send_quantity(32'd5, 0);
    send_meta(8'($urandom_range(255)), 28'd5);
    // running status carries across a meta event
    send_quantity(32'd0, 0);
    send_channel(stim_status, 1'b1);
    drain_results();
    write_meta_limit(8'd255);
    send_quantity(32'd0, 0);
    send_meta(8'($urandom_range(255)), 28'd1);
    drain_results();
  endtask

  task automatic test_random_files(input logic [7:0] limit, input int n_bytes);
    int stop_at;
    drain_results();
    write_meta_limit(limit);
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      send_delta();
      if ($urandom_range(99) < 72) begin
        if (stim_status != 8'h00 && $urandom_range(2) == 0)
          send_channel(stim_status, 1'b1);
        else
          send_channel(8'h80 + 8'($urandom_range(8'h6f)), 1'b0);
      end else begin
        send_meta(8'($urandom_range(255)),
                  28'(($urandom_range(3) != 0) ? $urandom_range(6) : $urandom_range(24, 7)));
      end
      if ($urandom_range(39) == 0) drain_results();
    end
  endtask

  task automatic test_sticky_error();
    case ($urandom_range(3))
      0: begin
        send_delta();
        send_byte(mfsp_pkg::StatusSys + 8'($urandom_range(14)));
      end
      1: repeat (6) send_byte(8'h80);
      2: begin
        send_byte(8'h81);
        repeat (3) send_byte(8'h80);
        send_byte(8'h00);
      end
      default: begin
        send_quantity(32'd0, 0);
        send_byte(mfsp_pkg::StatusMeta);
        send_byte(8'($urandom_range(255)));
        send_byte(8'h81);
        repeat (3) send_byte(8'h80);
        send_byte(8'h00);
      end
    endcase
    repeat (12) send_byte(8'($urandom_range(255)));
  endtask

  initial begin
    early_fault = $urandom_range(7);
    reset_model();
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    send_idle = 24;
    recv_idle = 53;
    test_file_header();
    test_channel_events();
    test_meta_limits();
    test_random_files(8'($urandom_range(6)), 100);
    send_idle = 53;
    recv_idle = 24;
    test_random_files(8'd255, 100);
    send_idle = 0;
    recv_idle = 0;
    test_random_files(8'($urandom_range(255)), 100);
    test_sticky_error();
    drain_results();
    repeat (6) @(negedge clk);
    if (fail_count == 0)
      $display("tb_midi_file_stream_parser_unit: clean");
    else
      $display("tb_midi_file_stream_parser_unit: errors");
    $finish;
  end

endmodule

### sim.f
sv/mfsp_pkg.sv
sv/midi_file_stream_parser_unit.sv
sv/mfsp_checker.sv
sim/tb_midi_file_stream_parser_unit.sv
